FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/plcm_pkg.sv
// ----------------------------------------------------------------------------
// plcm_pkg
// Types and codes of the piecewise-linear color map.
// ----------------------------------------------------------------------------
package plcm_pkg;

	localparam int OpcodeWidth   = 2;
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth  = 8;
	localparam int CountWidth    = 5;
	localparam int SlotWidth     = 4;

	typedef enum logic [OpcodeWidth-1:0] {
		OP_SCAN   = 2'd0,
		OP_MAP    = 2'd1,
		OP_LOAD   = 2'd2,
		OP_UNUSED = 2'd3
	} opcode_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_POINT_COUNT   = 3'd0,
		CFG_MASK_ENABLE   = 3'd1,
		CFG_INVALID_RED   = 3'd2,
		CFG_INVALID_GREEN = 3'd3,
		CFG_INVALID_BLUE  = 3'd4
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SRCH,
		ST_SCMP,
		ST_RDL,
		ST_RDR,
		ST_SETUP,
		ST_DIV,
		ST_MUL,
		ST_ACC
	} state_t;

endpackage

FILE: rtl/piecewise_linear_colormap.sv
// ----------------------------------------------------------------------------
// piecewise_linear_colormap
// Maps scalar samples to RGB bytes through a table of color control points.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Scan and load
// transactions finish in the cycle they are taken and never raise busy, so
// they can be issued back to back. A map transaction produces one color on
// red, green and blue, marked by done for exactly one cycle; the receiver
// cannot stall it, so it must take the color in that cycle. A masked-out map
// answers in the next cycle. Any other map is worked through a control-point
// memory with a registered read: a serial normalization (skipped when no range
// has been scanned or the sample lies at or outside the tracked range), a
// binary search whose steps alternate between a read state and a compare
// state and end in a state that picks the bracketing points, reads of the left
// and right points through ST_RDL, ST_RDR and ST_SETUP, a serial division for
// the interpolation fraction (skipped when both points share a position), and
// a shared multiply and scale pass for each of the three channels. Most of a
// map's time goes to the two serial dividers; done is raised as busy falls, so
// a new transaction can be taken in the cycle that done is shown.
// Configuration writes must only be issued while busy is low. The
// control-point memory has no reset; mapping against a point that was never
// loaded yields an unspecified color.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap #(
	parameter int MAX_POINTS    = 16,
	parameter int SAMPLE_WIDTH  = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [plcm_pkg::OpcodeWidth-1:0]    opcode,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	input  logic                                mask_valid,
	input  logic [plcm_pkg::SlotWidth-1:0]      point_index,
	input  logic [FRACTION_BITS:0]              point_position,
	input  logic [FRACTION_BITS:0]              point_red,
	input  logic [FRACTION_BITS:0]              point_green,
	input  logic [FRACTION_BITS:0]              point_blue,
	output logic                                done,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	input  logic                                cfg_we,
	input  logic [plcm_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [plcm_pkg::CfgDataWidth-1:0]   cfg_wdata
);
	import plcm_pkg::*;

	`include "assert_macros.svh"

	localparam int F   = FRACTION_BITS;
	localparam int W   = SAMPLE_WIDTH;
	localparam int V   = F + 1;                 // width of one stored value
	localparam int EW  = 4 * V;                 // position, red, green, blue
	localparam int IW  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int DW  = 2 * F + 1;             // dividend and quotient width
	localparam int CNW = $clog2(DW + 1);
	localparam int PW  = (F + 2) + (DW + 1);    // product width
	localparam int AW  = F + DW + 12;           // accumulator width
	localparam logic [V-1:0]  OneQ      = V'(1) << F;
	localparam logic [63:0]   FracLimit = 64'd1 << (54 - F);

	// Configuration registers.
	logic [CountWidth-1:0] point_count_q;
	logic                  mask_enable_q;
	logic [7:0]            inv_red_q, inv_green_q, inv_blue_q;

	// Tracked range, held as offset-binary keys so unsigned compares work.
	logic [W-1:0] range_min_q, range_max_q;
	logic         range_seen_q;

	// Control-point memory, one entry per point: {position, red, green, blue}.
	logic [EW-1:0] mem [MAX_POINTS];
	logic [EW-1:0] rd_q;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	state_t state_q, state_d;

	// Datapath registers.
	logic [W-1:0]         span_q;
	logic [W-1:0]         nrem_q;
	logic [F-1:0]         nquo_q;
	logic [V-1:0]         nv_q;
	logic [IW-1:0]        lo_q, hi_q;
	logic [IW-1:0]        left_q, right_q;
	logic [EW-1:0]        left_ent_q, right_ent_q;
	logic [CNW-1:0]       cnt_q;
	logic [V-1:0]         drem_q;
	logic [V-1:0]         dv_q;
	logic [DW-1:0]        dquo_q;
	logic                 neg_q;
	logic signed [DW:0]   frac_q;
	logic [1:0]           ch_q;
	logic signed [PW-1:0] prod_s1;
	logic                 done_q;
	logic [7:0]           red_q, green_q, blue_q;

	logic          accept;
	logic [W-1:0]  key;
	logic [IW-1:0] n_m1;
	logic [IW-1:0] mid;
	logic [V-1:0]  mid_pos;

	assign accept = start && !busy;
	assign key    = {~sample[W-1], sample[W-2:0]};
	assign busy   = (state_q != ST_IDLE);

	// Last usable point index, with the count clamped to 2..MAX_POINTS.
	always_comb begin
		if (point_count_q < CountWidth'(2)) begin
			n_m1 = IW'(1);
		end else if (int'(point_count_q) > MAX_POINTS) begin
			n_m1 = IW'(MAX_POINTS - 1);
		end else begin
			n_m1 = IW'(point_count_q - CountWidth'(1));
		end
	end

	assign mid     = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign mid_pos = rd_q[EW-1 -: V];

	function automatic logic [V-1:0] sat_one(input logic [V-1:0] raw);
		sat_one = (raw > OneQ) ? OneQ : raw;
	endfunction

	// Loads are written in the cycle they are taken.
	always_comb begin
		wr_en   = accept && (opcode_t'(opcode) == OP_LOAD) &&
		          (int'(point_index) < MAX_POINTS);
		wr_addr = IW'(point_index);
		wr_data = {sat_one(point_position), sat_one(point_red),
		           sat_one(point_green), sat_one(point_blue)};
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Next state and read address.
	always_comb begin
		state_d = state_q;
		rd_addr = mid;
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode_t'(opcode) == OP_MAP && !(mask_enable_q && !mask_valid)) begin
					if (!range_seen_q || range_max_q <= range_min_q ||
					    key <= range_min_q || key >= range_max_q) begin
						state_d = ST_SRCH;
					end else begin
						state_d = ST_NORM;
					end
				end
			end
			ST_NORM: begin
				if (cnt_q == CNW'(F - 1)) begin
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: begin
				rd_addr = mid;
				state_d = (lo_q < hi_q) ? ST_SCMP : ST_RDL;
			end
			ST_SCMP: begin
				state_d = ST_SRCH;
			end
			ST_RDL: begin
				rd_addr = left_q;
				state_d = ST_RDR;
			end
			ST_RDR: begin
				rd_addr = right_q;
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = (rd_q[EW-1 -: V] == left_ent_q[EW-1 -: V]) ? ST_MUL : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNW'(DW - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = (ch_q == 2'd2) ? ST_IDLE : ST_MUL;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration and range tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CountWidth'(2);
			mask_enable_q <= 1'b0;
			inv_red_q     <= '0;
			inv_green_q   <= '0;
			inv_blue_q    <= '0;
			range_min_q   <= '0;
			range_max_q   <= '0;
			range_seen_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_POINT_COUNT:   point_count_q <= cfg_wdata[CountWidth-1:0];
					CFG_MASK_ENABLE:   mask_enable_q <= cfg_wdata[0];
					CFG_INVALID_RED:   inv_red_q     <= cfg_wdata;
					CFG_INVALID_GREEN: inv_green_q   <= cfg_wdata;
					CFG_INVALID_BLUE:  inv_blue_q    <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept && opcode_t'(opcode) == OP_SCAN) begin
				range_seen_q <= 1'b1;
				if (!range_seen_q || key < range_min_q) begin
					range_min_q <= key;
				end
				if (!range_seen_q || key > range_max_q) begin
					range_max_q <= key;
				end
			end
		end
	end

	// Strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && opcode_t'(opcode) == OP_MAP && mask_enable_q && !mask_valid) ||
			          (state_q == ST_ACC && ch_q == 2'd2);
		end
	end

	// Datapath.
	logic [W:0]          n_two;
	logic [V:0]          d_t;
	logic signed [F+1:0] num, den;
	logic [F+1:0]        num_abs, den_abs;
	logic [DW-1:0]       q_mag, q_last;
	logic [V-1:0]        cl_sel, cr_sel;
	logic signed [F+1:0] diff;
	logic signed [AW-1:0] sum, acc, shifted;
	logic [7:0]          byte_out;

	always_comb begin
		n_two   = {nrem_q, 1'b0};
		d_t     = {drem_q, dquo_q[DW-1]};
		num     = $signed({1'b0, nv_q}) - $signed({1'b0, left_ent_q[EW-1 -: V]});
		den     = $signed({1'b0, rd_q[EW-1 -: V]}) - $signed({1'b0, left_ent_q[EW-1 -: V]});
		num_abs = num[F+1] ? -num : num;
		den_abs = den[F+1] ? -den : den;
		q_last  = {dquo_q[DW-2:0], (d_t >= {1'b0, dv_q})};
		q_mag   = (64'(q_last) > FracLimit) ? FracLimit[DW-1:0] : q_last;
		case (ch_q)
			2'd0: begin
				cl_sel = left_ent_q[3*V-1 -: V];
				cr_sel = right_ent_q[3*V-1 -: V];
			end
			2'd1: begin
				cl_sel = left_ent_q[2*V-1 -: V];
				cr_sel = right_ent_q[2*V-1 -: V];
			end
			default: begin
				cl_sel = left_ent_q[V-1:0];
				cr_sel = right_ent_q[V-1:0];
			end
		endcase
		diff    = $signed({1'b0, cr_sel}) - $signed({1'b0, cl_sel});
		sum     = (AW'($signed({1'b0, cl_sel})) <<< F) + AW'(prod_s1);
		acc     = (sum <<< 8) - sum;
		shifted = acc >>> (2 * F);
		if (acc < 0) begin
			byte_out = 8'd0;
		end else if (shifted > AW'(255)) begin
			byte_out = 8'd255;
		end else begin
			byte_out = shifted[7:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				span_q <= range_max_q - range_min_q;
				nrem_q <= key - range_min_q;
				cnt_q  <= '0;
				lo_q   <= '0;
				hi_q   <= n_m1;
				if (!range_seen_q || range_max_q <= range_min_q || key <= range_min_q) begin
					nv_q <= '0;
				end else begin
					nv_q <= OneQ;
				end
				if (accept && opcode_t'(opcode) == OP_MAP && mask_enable_q && !mask_valid) begin
					red_q   <= inv_red_q;
					green_q <= inv_green_q;
					blue_q  <= inv_blue_q;
				end
			end
			ST_NORM: begin
				cnt_q <= cnt_q + CNW'(1);
				if (n_two >= {1'b0, span_q}) begin
					nrem_q <= W'(n_two - {1'b0, span_q});
					nquo_q <= {nquo_q[F-2:0], 1'b1};
					if (cnt_q == CNW'(F - 1)) nv_q <= {1'b0, nquo_q[F-2:0], 1'b1};
				end else begin
					nrem_q <= n_two[W-1:0];
					nquo_q <= {nquo_q[F-2:0], 1'b0};
					if (cnt_q == CNW'(F - 1)) nv_q <= {1'b0, nquo_q[F-2:0], 1'b0};
				end
			end
			ST_SRCH: begin
				if (lo_q >= hi_q) begin
					if (lo_q == '0) begin
						left_q  <= '0;
						right_q <= IW'(1);
					end else begin
						left_q  <= lo_q - IW'(1);
						right_q <= lo_q;
					end
				end
			end
			ST_SCMP: begin
				if (nv_q > mid_pos) begin
					lo_q <= mid + IW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			ST_RDR: begin
				left_ent_q <= rd_q;
			end
			ST_SETUP: begin
				right_ent_q <= rd_q;
				neg_q       <= num[F+1] ^ den[F+1];
				dv_q        <= den_abs[V-1:0];
				drem_q      <= '0;
				dquo_q      <= DW'(num_abs[V-1:0]) << F;
				cnt_q       <= '0;
				frac_q      <= '0;
				ch_q        <= 2'd0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + CNW'(1);
				if (d_t >= {1'b0, dv_q}) begin
					drem_q <= V'(d_t - {1'b0, dv_q});
				end else begin
					drem_q <= d_t[V-1:0];
				end
				dquo_q <= q_last;
				if (cnt_q == CNW'(DW - 1)) begin
					frac_q <= neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
				end
			end
			ST_MUL: begin
				prod_s1 <= PW'(diff) * PW'(frac_q);
			end
			ST_ACC: begin
				ch_q <= ch_q + 2'd1;
				case (ch_q)
					2'd0:    red_q   <= byte_out;
					2'd1:    green_q <= byte_out;
					default: blue_q  <= byte_out;
				endcase
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

	// A color is only ever shown after the last channel or a masked map.
	`ASSERT_IMPLIES(a_done_source, done, $past(state_q) == ST_ACC || $past(accept), "done without a finished map")
	// The search window never inverts while it is being narrowed.
	`ASSERT_IMPLIES(a_search_window, state_q == ST_SCMP, lo_q < hi_q, "search window inverted")
	// The channel counter only walks red, green and blue.
	`ASSERT_IMPLIES(a_channel_range, state_q == ST_MUL || state_q == ST_ACC, ch_q != 2'd3, "channel counter out of range")

endmodule
